/* rtl/med_pkg.sv */
// ----------------------------------------------------------------------------
// med_pkg
// Widths, codes and constants shared by the MIDI event dispatcher.
// ----------------------------------------------------------------------------
package med_pkg;

   localparam int CHANNELS      = 16;
   localparam int FRACTION_BITS = 16;

   localparam int CH_W    = $clog2(CHANNELS);
   localparam int CMD_W   = 3;
   localparam int DELAY_W = 28;
   localparam int DATA_W  = 8;
   localparam int TEMPO_W = 24;
   localparam int TIME_W  = 64;
   localparam int TICK_W  = 41;
   localparam int TPQ_W   = 16;
   localparam int KIND_W  = 3;
   localparam int BEND_W  = 14;
   localparam int CSR_W   = 64;
   localparam int CSR_IDX_W = 2;

   // tempo divider: dividend is tempo << FRACTION_BITS, divisor is a positive division
   localparam int DIV_W     = TEMPO_W + FRACTION_BITS;
   localparam int DIV_CNT_W = $clog2(DIV_W);
   localparam int REM_W     = TPQ_W - 1;

   localparam logic [TIME_W-1:0] TICK_MAX = TIME_W'((64'd1 << TICK_W) - 64'd1);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TICKS_PER_QUARTER = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TICK_DURATION     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_START_TIME        = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SKIPPED_TICKS     = 2'd3;

   localparam logic [TPQ_W-1:0]  TPQ_RESET  = 16'd96;
   localparam logic [TICK_W-1:0] TICK_RESET = 41'd341333333;

   // event commands
   localparam logic [CMD_W-1:0] CMD_NOTE_OFF   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_NOTE_ON    = 3'd1;
   localparam logic [CMD_W-1:0] CMD_CONTROL    = 3'd2;
   localparam logic [CMD_W-1:0] CMD_PROGRAM    = 3'd3;
   localparam logic [CMD_W-1:0] CMD_PITCH_BEND = 3'd4;
   localparam logic [CMD_W-1:0] CMD_SYSTEM     = 3'd5;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_VOLUME   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_PAN      = 3'd1;
   localparam logic [KIND_W-1:0] KIND_REVERB   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_ALL_OFF  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_PROGRAM  = 3'd4;
   localparam logic [KIND_W-1:0] KIND_NOTE_ON  = 3'd5;
   localparam logic [KIND_W-1:0] KIND_NOTE_OFF = 3'd6;
   localparam logic [KIND_W-1:0] KIND_BEND     = 3'd7;

   localparam logic [DATA_W-1:0] CC_VOLUME      = 8'd7;
   localparam logic [DATA_W-1:0] CC_PAN         = 8'd10;
   localparam logic [DATA_W-1:0] CC_REVERB      = 8'd91;
   localparam logic [DATA_W-1:0] CC_ALL_OFF_LO  = 8'd123;
   localparam logic [DATA_W-1:0] CC_ALL_OFF_HI  = 8'd127;
   localparam logic [DATA_W-1:0] PROGRAM_LIMIT  = 8'd128;
   localparam logic [DATA_W-1:0] DRUM_OFFSET    = 8'd128;
   localparam logic [DATA_W-1:0] NOTE_OFF_VELOCITY = 8'd64;
   localparam logic [DATA_W-1:0] META_STATUS    = 8'hFF;
   localparam logic [DATA_W-1:0] META_TEMPO     = 8'h51;
   localparam logic [CH_W-1:0]   DRUM_CHANNEL   = 4'd9;
   localparam logic [BEND_W-1:0] BEND_CENTRE    = 14'd8192;

endpackage

/* rtl/midi_event_dispatcher_unit.sv */
// Sequence: an accepted item goes to ST_MUL, where the shift-add multiplier takes one step per
// bit of the effective delay (0 to 28 bits); an applied tempo event then runs ST_DIV, one
// divider bit per cycle over 40 bits; then ST_EMIT. No new item is taken until the last one
// leaves ST_EMIT; a held result stalls the next item.
// Reset (synchronous, active high) restores state, timing and valid registers to defaults and clears
// the program table; datapath and payload registers are not reset. The block is ready as soon as reset falls.
// ----------------------------------------------------------------------------
// midi_event_dispatcher_unit
// Decodes MIDI track events, keeps a fixed-point event clock via a shift-add
// multiplier and recomputes the tick length on tempo events via a serial divider.
// ----------------------------------------------------------------------------
module midi_event_dispatcher_unit
   import med_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,

   input  logic                     csr_we,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [CSR_W-1:0]         csr_wdata,

   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [CMD_W-1:0]         req_cmd,
   input  logic [DELAY_W-1:0]       req_delay_ticks,
   input  logic [CH_W-1:0]          req_channel_number,
   input  logic [DATA_W-1:0]        req_first_data,
   input  logic [DATA_W-1:0]        req_second_data,
   input  logic [DATA_W-1:0]        req_status_byte,
   input  logic [TEMPO_W-1:0]       req_tempo_value,

   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [KIND_W-1:0]        rsp_event_kind,
   output logic [TIME_W-1:0]        rsp_event_time,
   output logic [CH_W-1:0]          rsp_out_channel,
   output logic [DATA_W-1:0]        rsp_note_key,
   output logic [DATA_W-1:0]        rsp_amount,
   output logic [DATA_W-1:0]        rsp_note_program,
   output logic signed [BEND_W-1:0] rsp_bend_amount
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MUL  = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;
   localparam logic [1:0] ST_EMIT = 2'd3;

   logic [1:0]            state_ff, state_in;
   logic [TPQ_W-1:0]      tpq_ff, tpq_in;
   logic [TICK_W-1:0]     tick_ff, tick_in;
   logic [TIME_W-1:0]     clock_ff, clock_in;
   logic [DELAY_W-1:0]    skip_ff, skip_in;
   logic [TIME_W-1:0]     mcand_ff, mcand_in;
   logic [DELAY_W-1:0]    mplier_ff, mplier_in;
   logic [DIV_W-1:0]      quo_ff, quo_in;
   logic [REM_W-1:0]      rem_ff, rem_in;
   logic [DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DATA_W-1:0]     prog_ff [CHANNELS];
   logic                  prog_we;
   logic                  rsp_valid_ff, rsp_valid_in;

   // latched item
   logic [CMD_W-1:0]      cmd_ff;
   logic [CH_W-1:0]       ch_ff;
   logic [DATA_W-1:0]     d0_ff, d1_ff, status_ff;
   logic [TEMPO_W-1:0]    tempo_ff;

   logic [KIND_W-1:0]     kind_ff;
   logic [TIME_W-1:0]     time_ff;
   logic [CH_W-1:0]       och_ff;
   logic [DATA_W-1:0]     key_ff, amt_ff, nprog_ff;
   logic [BEND_W-1:0]     bend_ff;

   logic                  accept;
   logic                  tempo_hit;
   logic [REM_W:0]        trial;
   logic [REM_W:0]        diff;
   logic                  ge;
   logic [TIME_W-1:0]     quo_wide;
   logic                  out_free;

   logic                  has_res;
   logic [KIND_W-1:0]     kind_c;
   logic [DATA_W-1:0]     key_c, amt_c, nprog_c;
   logic [BEND_W-1:0]     bend_c;
   logic [BEND_W-1:0]     bend_cat;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE) && !reset;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign tempo_hit = (cmd_ff == CMD_SYSTEM) && (status_ff == META_STATUS)
                      && (d0_ff == META_TEMPO) && !tpq_ff[TPQ_W-1] && (tpq_ff != '0);

   // restoring divider step, one quotient bit per cycle
   assign trial    = {rem_ff, quo_ff[DIV_W-1]};
   assign ge       = trial >= {1'b0, tpq_ff[REM_W-1:0]};
   assign diff     = trial - {1'b0, tpq_ff[REM_W-1:0]};
   assign quo_wide = TIME_W'(quo_in);

   // high data bits are ORed in unmasked; only the low 14 bits survive
   assign bend_cat = {d1_ff[BEND_W-8:0], 7'b0} | {6'b0, d0_ff};

   // result decode
   always_comb begin
      has_res = 1'b0;
      kind_c  = KIND_VOLUME;
      key_c   = '0;
      amt_c   = '0;
      nprog_c = '0;
      bend_c  = '0;
      prog_we = 1'b0;
      unique case (cmd_ff)
         CMD_NOTE_OFF: begin
            has_res = 1'b1;
            kind_c  = KIND_NOTE_OFF;
            key_c   = d0_ff;
            amt_c   = d1_ff;
         end
         CMD_NOTE_ON: begin
            has_res = 1'b1;
            key_c   = d0_ff;
            if (d1_ff != '0) begin
               kind_c  = KIND_NOTE_ON;
               amt_c   = d1_ff;
               nprog_c = (ch_ff == DRUM_CHANNEL) ? d0_ff + DRUM_OFFSET : prog_ff[ch_ff];
            end else begin
               kind_c = KIND_NOTE_OFF;
               amt_c  = NOTE_OFF_VELOCITY;
            end
         end
         CMD_CONTROL: begin
            amt_c = d1_ff;
            if (d0_ff == CC_VOLUME) begin
               has_res = 1'b1;
               kind_c  = KIND_VOLUME;
            end else if (d0_ff == CC_PAN) begin
               has_res = 1'b1;
               kind_c  = KIND_PAN;
            end else if (d0_ff == CC_REVERB) begin
               has_res = 1'b1;
               kind_c  = KIND_REVERB;
            end else if (d0_ff >= CC_ALL_OFF_LO && d0_ff <= CC_ALL_OFF_HI) begin
               has_res = 1'b1;
               kind_c  = KIND_ALL_OFF;
               amt_c   = '0;
            end
         end
         CMD_PROGRAM: begin
            kind_c = KIND_PROGRAM;
            amt_c  = d0_ff;
            if (d0_ff < PROGRAM_LIMIT) begin
               has_res = 1'b1;
               prog_we = 1'b1;
            end
         end
         CMD_PITCH_BEND: begin
            has_res = 1'b1;
            kind_c  = KIND_BEND;
            bend_c  = bend_cat - BEND_CENTRE;
         end
         default: begin
            has_res = 1'b0;
         end
      endcase
   end

   // sequencer and next state
   always_comb begin
      state_in     = state_ff;
      tpq_in       = tpq_ff;
      tick_in      = tick_ff;
      clock_in     = clock_ff;
      skip_in      = skip_ff;
      mcand_in     = mcand_ff;
      mplier_in    = mplier_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               // consume skipped ticks before any time passes
               if (req_delay_ticks > skip_ff) begin
                  mplier_in = req_delay_ticks - skip_ff;
                  skip_in   = '0;
               end else begin
                  mplier_in = '0;
                  skip_in   = skip_ff - req_delay_ticks;
               end
               mcand_in = TIME_W'(tick_ff);
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            if (mplier_ff == '0) begin
               quo_in = DIV_W'(tempo_ff) << FRACTION_BITS;
               rem_in = '0;
               cnt_in = '0;
               state_in = tempo_hit ? ST_DIV : ST_EMIT;
            end else begin
               if (mplier_ff[0]) begin
                  clock_in = clock_ff + mcand_ff;
               end
               mcand_in  = mcand_ff << 1;
               mplier_in = mplier_ff >> 1;
            end
         end
         ST_DIV: begin
            rem_in = ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], ge};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DIV_CNT_W'(DIV_W - 1)) begin
               tick_in  = (quo_wide > TICK_MAX) ? TICK_MAX[TICK_W-1:0] : quo_wide[TICK_W-1:0];
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // hold until the output register is free
            if (out_free) begin
               rsp_valid_in = has_res;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_we) begin
         unique case (csr_index)
            CSR_TICKS_PER_QUARTER: tpq_in   = csr_wdata[TPQ_W-1:0];
            CSR_TICK_DURATION:     tick_in  = csr_wdata[TICK_W-1:0];
            CSR_START_TIME:        clock_in = csr_wdata[TIME_W-1:0];
            CSR_SKIPPED_TICKS:     skip_in  = csr_wdata[DELAY_W-1:0];
            default:               tpq_in   = tpq_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tpq_ff       <= TPQ_RESET;
         tick_ff      <= TICK_RESET;
         clock_ff     <= '0;
         skip_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) begin
            prog_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         tpq_ff       <= tpq_in;
         tick_ff      <= tick_in;
         clock_ff     <= clock_in;
         skip_ff      <= skip_in;
         rsp_valid_ff <= rsp_valid_in;
         if (state_ff == ST_EMIT && out_free && prog_we) begin
            prog_ff[ch_ff] <= d0_ff;
         end
      end
   end

   // datapath and payload registers
   always_ff @(posedge clock) begin
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      quo_ff    <= quo_in;
      rem_ff    <= rem_in;
      cnt_ff    <= cnt_in;
      if (accept) begin
         cmd_ff    <= req_cmd;
         ch_ff     <= req_channel_number;
         d0_ff     <= req_first_data;
         d1_ff     <= req_second_data;
         status_ff <= req_status_byte;
         tempo_ff  <= req_tempo_value;
      end
      if (state_ff == ST_EMIT && out_free) begin
         kind_ff  <= kind_c;
         time_ff  <= clock_ff;
         och_ff   <= ch_ff;
         key_ff   <= key_c;
         amt_ff   <= amt_c;
         nprog_ff <= nprog_c;
         bend_ff  <= bend_c;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_event_kind   = kind_ff;
   assign rsp_event_time   = time_ff;
   assign rsp_out_channel  = och_ff;
   assign rsp_note_key     = key_ff;
   assign rsp_amount       = amt_ff;
   assign rsp_note_program = nprog_ff;
   assign rsp_bend_amount  = $signed(bend_ff);

   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ready)
      else $error("input taken while an item is in progress");

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (rem_ff < tpq_ff[REM_W-1:0]))
      else $error("divider remainder not below divisor");

   a_skip_means_no_time: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL && skip_ff != '0) |-> (mplier_ff == '0))
      else $error("time advanced while skipped ticks remain");

   a_div_only_on_tempo: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> tempo_hit)
      else $error("divider running for a non-tempo event");

endmodule

/* tb/sv/med_tb_pkg.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// med_tb_pkg
// Event and result types plus the dispatch scoreboard: predicts the result of
// every accepted MIDI event and checks the results in order.
// ----------------------------------------------------------------------------
package med_tb_pkg;
   import med_pkg::*;

   // command codes that the block does not decode
   localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
   localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic [CMD_W-1:0]   cmd;
      logic [DELAY_W-1:0] delay;
      logic [CH_W-1:0]    channel;
      logic [DATA_W-1:0]  first;
      logic [DATA_W-1:0]  second;
      logic [DATA_W-1:0]  status;
      logic [TEMPO_W-1:0] tempo;
   } midi_event_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [TIME_W-1:0] stamp;
      logic [CH_W-1:0]   channel;
      logic [DATA_W-1:0] key;
      logic [DATA_W-1:0] amount;
      logic [DATA_W-1:0] prog_num;
      logic [BEND_W-1:0] bend;
   } dispatch_type;

   class dispatch_scoreboard;
      logic [TPQ_W-1:0]   tpq;
      logic [TICK_W-1:0]  tick_len;
      logic [TIME_W-1:0]  clock_time;
      logic [DELAY_W-1:0] skipped;
      logic [DATA_W-1:0]  prog_map [CHANNELS];
      dispatch_type       expected [$];
      int                 errors;
      int                 results_seen;

      function new();
         tpq          = TPQ_RESET;
         tick_len     = TICK_RESET;
         clock_time   = '0;
         skipped      = '0;
         errors       = 0;
         results_seen = 0;
         foreach (prog_map[i]) prog_map[i] = '0;
      endfunction

      function void flag(string msg);
         errors++;
         if (errors <= MAX_REPORTS) $display("%s", msg);
      endfunction

      // loading a register also reloads the state it seeds
      function void apply_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] data);
         case (idx)
            CSR_TICKS_PER_QUARTER: tpq        = data[TPQ_W-1:0];
            CSR_TICK_DURATION:     tick_len   = data[TICK_W-1:0];
            CSR_START_TIME:        clock_time = data;
            CSR_SKIPPED_TICKS:     skipped    = data[DELAY_W-1:0];
            default: ;
         endcase
      endfunction

      function void note_event(midi_event_type ev);
         logic [63:0]  span;
         logic [63:0]  quot;
         logic [15:0]  raw;
         dispatch_type d;
         bit           emits;
         span = 64'(ev.delay);
         // consume skipped ticks before any time passes
         if (span > 64'(skipped)) begin
            span    = span - 64'(skipped);
            skipped = '0;
         end else begin
            skipped = skipped - span[DELAY_W-1:0];
            span    = '0;
         end
         clock_time = clock_time + span * 64'(tick_len);

         d         = '0;
         d.stamp   = clock_time;
         d.channel = ev.channel;
         emits     = 1'b1;
         case (ev.cmd)
            CMD_SYSTEM: begin
               emits = 1'b0;
               if (ev.status == META_STATUS && ev.first == META_TEMPO &&
                   tpq != '0 && !tpq[TPQ_W-1]) begin
                  quot     = (64'(ev.tempo) << FRACTION_BITS) / 64'(tpq);
                  tick_len = (quot > TICK_MAX) ? TICK_MAX[TICK_W-1:0] : quot[TICK_W-1:0];
               end
            end
            CMD_CONTROL: begin
               d.amount = ev.second;
               if (ev.first == CC_VOLUME)      d.kind = KIND_VOLUME;
               else if (ev.first == CC_PAN)    d.kind = KIND_PAN;
               else if (ev.first == CC_REVERB) d.kind = KIND_REVERB;
               else if (ev.first >= CC_ALL_OFF_LO && ev.first <= CC_ALL_OFF_HI) begin
                  d.kind   = KIND_ALL_OFF;
                  d.amount = '0;
               end else emits = 1'b0;
            end
            CMD_PROGRAM: begin
               if (ev.first < PROGRAM_LIMIT) begin
                  prog_map[ev.channel] = ev.first;
                  d.kind   = KIND_PROGRAM;
                  d.amount = ev.first;
               end else emits = 1'b0;
            end
            CMD_NOTE_ON: begin
               d.key = ev.first;
               if (ev.second != '0) begin
                  d.kind     = KIND_NOTE_ON;
                  d.amount   = ev.second;
                  d.prog_num = (ev.channel == DRUM_CHANNEL) ? ev.first + DRUM_OFFSET
                                                             : prog_map[ev.channel];
               end else begin
                  d.kind   = KIND_NOTE_OFF;
                  d.amount = NOTE_OFF_VELOCITY;
               end
            end
            CMD_NOTE_OFF: begin
               d.kind   = KIND_NOTE_OFF;
               d.key    = ev.first;
               d.amount = ev.second;
            end
            CMD_PITCH_BEND: begin
               // high data bits are ORed in unmasked
               raw    = ({8'h00, ev.second} << 7) | {8'h00, ev.first};
               d.kind = KIND_BEND;
               d.bend = raw[BEND_W-1:0] - BEND_CENTRE;
            end
            default: emits = 1'b0;
         endcase
         if (emits) expected.push_back(d);
      endfunction

      function void check_dispatch(dispatch_type got);
         dispatch_type want;
         string        diffs;
         results_seen++;
         if (expected.size() == 0) begin
            flag($sformatf("result %0d unexpected: kind %0d time %h ch %0d",
                           results_seen, got.kind, got.stamp, got.channel));
            return;
         end
         want  = expected.pop_front();
         diffs = "";
         if (got.kind     != want.kind)     diffs = {diffs, " kind"};
         if (got.stamp    != want.stamp)    diffs = {diffs, " time"};
         if (got.channel  != want.channel)  diffs = {diffs, " channel"};
         if (got.key      != want.key)      diffs = {diffs, " key"};
         if (got.amount   != want.amount)   diffs = {diffs, " amount"};
         if (got.prog_num != want.prog_num) diffs = {diffs, " program"};
         if (got.bend     != want.bend)     diffs = {diffs, " bend"};
         if (diffs != "")
            flag($sformatf({"result %0d wrong%s: expected kind %0d time %h ch %0d key %0d ",
                            "amt %0d prog %0d bend %0d, got kind %0d time %h ch %0d key %0d ",
                            "amt %0d prog %0d bend %0d"},
                           results_seen, diffs,
                           want.kind, want.stamp, want.channel, want.key, want.amount,
                           want.prog_num, $signed(want.bend),
                           got.kind, got.stamp, got.channel, got.key, got.amount,
                           got.prog_num, $signed(got.bend)));
      endfunction

      function int outstanding();
         return expected.size();
      endfunction

      function void close_out();
         if (expected.size() != 0)
            flag($sformatf("%0d results never arrived", expected.size()));
      endfunction
   endclass

endpackage

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives MIDI events into the dispatcher in random bursts under several clock
// and division settings, stalls the result side, and checks every result.
// ----------------------------------------------------------------------------
module testbench;
   import med_pkg::*;
   import med_tb_pkg::*;

   localparam int ITEMS_PER_PHASE = 190;
   localparam int PHASES          = 7;
   // margin covers the multiply and divide steps plus any wait on the output register
   localparam int SETTLE_CYCLES   = 120;
   localparam int CYCLE_LIMIT     = 1_000_000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                 csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]     csr_wdata = '0;

   logic               req_valid          = 1'b0;
   logic               req_ready;
   logic [CMD_W-1:0]   req_cmd            = '0;
   logic [DELAY_W-1:0] req_delay_ticks    = '0;
   logic [CH_W-1:0]    req_channel_number = '0;
   logic [DATA_W-1:0]  req_first_data     = '0;
   logic [DATA_W-1:0]  req_second_data    = '0;
   logic [DATA_W-1:0]  req_status_byte    = '0;
   logic [TEMPO_W-1:0] req_tempo_value    = '0;

   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [KIND_W-1:0]        rsp_event_kind;
   logic [TIME_W-1:0]        rsp_event_time;
   logic [CH_W-1:0]          rsp_out_channel;
   logic [DATA_W-1:0]        rsp_note_key;
   logic [DATA_W-1:0]        rsp_amount;
   logic [DATA_W-1:0]        rsp_note_program;
   logic signed [BEND_W-1:0] rsp_bend_amount;

   dispatch_scoreboard sb;
   int burst_left  = 0;
   int cycle_count = 0;
   int rx_cycle    = 0;
   int stall_mode  = 0;

   midi_event_dispatcher_unit u_top (.*);

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // result side: check each transfer, stall on a pattern that changes now and then
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready)
            sb.check_dispatch('{rsp_event_kind, rsp_event_time, rsp_out_channel, rsp_note_key,
                                rsp_amount, rsp_note_program, rsp_bend_amount});
         case (stall_mode)
            0:       rsp_ready <= 1'b1;
            1:       rsp_ready <= ($urandom_range(0, 3) != 0);
            2:       rsp_ready <= 1'($urandom_range(0, 1));
            default: rsp_ready <= (rx_cycle % 13) >= 9;
         endcase
         rx_cycle <= rx_cycle + 1;
         if (rx_cycle % 256 == 255) stall_mode <= $urandom_range(0, 3);
      end
   end

   function automatic midi_event_type ev_of(logic [CMD_W-1:0] cmd, logic [DELAY_W-1:0] delay,
                                            logic [CH_W-1:0] ch, logic [DATA_W-1:0] d0,
                                            logic [DATA_W-1:0] d1, logic [DATA_W-1:0] st,
                                            logic [TEMPO_W-1:0] tempo);
      return '{cmd, delay, ch, d0, d1, st, tempo};
   endfunction

   function automatic midi_event_type random_event();
      midi_event_type ev;
      int pick;
      int dsel;
      ev.channel = ($urandom_range(0, 5) == 0) ? DRUM_CHANNEL : CH_W'($urandom_range(0, 15));
      ev.first   = DATA_W'($urandom);
      ev.second  = DATA_W'($urandom);
      ev.status  = DATA_W'($urandom);
      ev.tempo   = TEMPO_W'($urandom);
      dsel = $urandom_range(0, 99);
      if (dsel < 40)      ev.delay = '0;
      else if (dsel < 70) ev.delay = DELAY_W'($urandom_range(0, 15));
      else if (dsel < 90) ev.delay = DELAY_W'($urandom_range(0, 65535));
      else                ev.delay = DELAY_W'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 14) begin
         ev.cmd = CMD_NOTE_OFF;
      end else if (pick < 34) begin
         ev.cmd = CMD_NOTE_ON;
         if ($urandom_range(0, 4) == 0) ev.second = '0;
      end else if (pick < 54) begin
         ev.cmd = CMD_CONTROL;
         if ($urandom_range(0, 9) < 7)
            case ($urandom_range(0, 3))
               0:       ev.first = CC_VOLUME;
               1:       ev.first = CC_PAN;
               2:       ev.first = CC_REVERB;
               default: ev.first = DATA_W'($urandom_range(CC_ALL_OFF_LO, CC_ALL_OFF_HI));
            endcase
      end else if (pick < 64) begin
         ev.cmd = CMD_PROGRAM;
         if ($urandom_range(0, 4) != 0) ev.first[DATA_W-1] = 1'b0;
      end else if (pick < 76) begin
         ev.cmd = CMD_PITCH_BEND;
      end else if (pick < 96) begin
         ev.cmd = CMD_SYSTEM;
         if ($urandom_range(0, 9) < 6) begin
            ev.status = META_STATUS;
            ev.first  = META_TEMPO;
            if ($urandom_range(0, 1) == 0) ev.tempo = TEMPO_W'($urandom_range(50000, 2000000));
         end
      end else begin
         ev.cmd = $urandom_range(0, 1) ? CMD_SPARE_LO : CMD_SPARE_HI;
      end
      return ev;
   endfunction

   // present one event; between bursts valid usually drops for a random gap, within a burst it stays high
   task automatic send_event(midi_event_type ev);
      if (burst_left == 0) begin
         if ($urandom_range(0, 7) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 9) == 0) ? 80 : $urandom_range(1, 24);
      end
      burst_left--;
      req_valid          <= 1'b1;
      req_cmd            <= ev.cmd;
      req_delay_ticks    <= ev.delay;
      req_channel_number <= ev.channel;
      req_first_data     <= ev.first;
      req_second_data    <= ev.second;
      req_status_byte    <= ev.status;
      req_tempo_value    <= ev.tempo;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_event(ev);
   endtask

   // write enable is left high; the caller drops it after the last write
   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      sb.apply_register(idx, data);
   endtask

   task automatic drain();
      req_valid  <= 1'b0;
      burst_left = 0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      logic [63:0] tpq_w;
      logic [63:0] tick_w;
      logic [63:0] start_w;
      logic [63:0] skip_w;
      sb = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part on reset settings
      send_event(ev_of(CMD_NOTE_OFF,   '0,     4'd0,  8'd0,   8'd0,   8'h00, '0));
      send_event(ev_of(CMD_NOTE_ON,    28'd1,  4'd15, 8'd255, 8'd255, 8'h00, '0));
      send_event(ev_of(CMD_NOTE_ON,    28'd5,  4'd3,  8'd60,  8'd0,   8'h00, '0));
      send_event(ev_of(CMD_PROGRAM,    '0,     4'd2,  8'd127, 8'd10,  8'h00, '0));
      send_event(ev_of(CMD_PROGRAM,    28'd2,  4'd2,  8'd128, 8'd0,   8'h00, '0));
      send_event(ev_of(CMD_NOTE_ON,    '0,     4'd2,  8'd64,  8'd100, 8'h00, '0));
      send_event(ev_of(CMD_NOTE_ON,    28'd3,  DRUM_CHANNEL, 8'd36,  8'd90, 8'h00, '0));
      send_event(ev_of(CMD_NOTE_ON,    '0,     DRUM_CHANNEL, 8'd200, 8'd1,  8'h00, '0));
      send_event(ev_of(CMD_CONTROL,    '0,     4'd1,  CC_VOLUME,     8'd255, 8'h00, '0));
      send_event(ev_of(CMD_CONTROL,    28'd7,  4'd1,  CC_PAN,        8'd0,   8'h00, '0));
      send_event(ev_of(CMD_CONTROL,    '0,     4'd5,  CC_REVERB,     8'd127, 8'h00, '0));
      send_event(ev_of(CMD_CONTROL,    '0,     4'd6,  CC_ALL_OFF_LO, 8'd33,  8'h00, '0));
      send_event(ev_of(CMD_CONTROL,    28'd1,  4'd7,  CC_ALL_OFF_HI, 8'd200, 8'h00, '0));
      send_event(ev_of(CMD_CONTROL,    '0,     4'd8,  8'd122,  8'd5,   8'h00, '0));
      send_event(ev_of(CMD_CONTROL,    '0,     4'd8,  8'd128,  8'd5,   8'h00, '0));
      send_event(ev_of(CMD_PITCH_BEND, '0,     4'd0,  8'd0,    8'd0,   8'h00, '0));
      send_event(ev_of(CMD_PITCH_BEND, 28'd2,  4'd0,  8'd127,  8'd127, 8'h00, '0));
      send_event(ev_of(CMD_PITCH_BEND, '0,     4'd11, 8'd255,  8'd255, 8'h00, '0));
      send_event(ev_of(CMD_PITCH_BEND, '0,     4'd12, 8'd0,    8'd64,  8'h00, '0));
      send_event(ev_of(CMD_SYSTEM,     '1,     4'd0,  META_TEMPO, 8'd0, META_STATUS, '1));
      send_event(ev_of(CMD_SYSTEM,     28'd4,  4'd0,  META_TEMPO, 8'd0, 8'hF0, 24'd500000));
      send_event(ev_of(CMD_SYSTEM,     '0,     4'd0,  8'h2F,   8'd0,   META_STATUS, 24'd1));
      send_event(ev_of(CMD_SYSTEM,     28'd9,  4'd0,  META_TEMPO, 8'd0, META_STATUS, '0));
      send_event(ev_of(CMD_SPARE_LO,   28'd11, 4'd0,  8'd1,    8'd1,   8'h00, '0));
      send_event(ev_of(CMD_SPARE_HI,   '1,     4'd15, 8'd1,    8'd1,   8'h00, '0));

      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase != 0) begin
            drain();
            tick_w  = {$urandom, $urandom} & 64'(TICK_MAX);
            start_w = {$urandom, $urandom};
            skip_w  = 64'($urandom_range(0, 4095));
            case (phase)
               1: begin
                  tpq_w = 64'd1; tick_w = TICK_MAX;
                  start_w = 64'hFFFF_FFFF_FFF0_0000; skip_w = '0;
               end
               2: begin
                  tpq_w = 64'h7FFF; tick_w = '0; start_w = '1;
                  skip_w = 64'((64'd1 << DELAY_W) - 64'd1);
               end
               3: begin
                  tpq_w = 64'h8000; tick_w = 64'd1; start_w = '0;
               end
               4: begin
                  tpq_w = '0; skip_w = '0;
               end
               5: begin
                  tpq_w = 64'hFFFF; skip_w = 64'($urandom) & 64'h0FFF_FFFF;
               end
               default: tpq_w = 64'($urandom_range(1, 32767));
            endcase
            write_csr(CSR_TICKS_PER_QUARTER, tpq_w);
            write_csr(CSR_TICK_DURATION,     tick_w);
            write_csr(CSR_START_TIME,        start_w);
            write_csr(CSR_SKIPPED_TICKS,     skip_w);
            csr_we <= 1'b0;
            @(posedge clock);
         end
         for (int n = 0; n < ITEMS_PER_PHASE; n++) send_event(random_event());
      end

      drain();
      sb.close_out();
      if (sb.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
